/* src/ifb_pkg.sv */
// Shared types and constants for the indexed framebuffer engine.
`default_nettype none
package ifb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int DIM_W  = 9;
  localparam int PROD_W = 18;
  localparam int CFG_AW = 4;

  typedef enum logic [2:0] {
    CMD_FILL      = 3'd0,
    CMD_BLIT_START = 3'd1,
    CMD_BLIT_DATA = 3'd2,
    CMD_PAL_WRITE = 3'd3,
    CMD_SCAN      = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN_RD,
    ST_SCAN_PAL,
    ST_SCAN_OUT
  } state_t;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR_MODEL  = 2'd2;

  localparam logic [1:0] BYTES_RGB565 = 2'd2;
  localparam logic [1:0] BYTES_RGB666 = 2'd3;

endpackage
`default_nettype wire

/* src/ifb_mac.sv */
// Shared registered multiply-add unit: res = a * b + c.
`default_nettype none
module ifb_mac (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [ifb_pkg::DIM_W-1:0]   a,
  input  wire logic [ifb_pkg::DIM_W-1:0]   b,
  input  wire logic [ifb_pkg::DIM_W-1:0]   c,
  output logic      [ifb_pkg::PROD_W-1:0]  res
);

  localparam int PW = ifb_pkg::PROD_W;

  logic [PW-1:0] res_r;
  logic [PW-1:0] res_nxt;

  always_comb begin
    res_nxt = PW'(a) * PW'(b) + PW'(c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

/* src/ifb_ram.sv */
// Simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module ifb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [DATA_W-1:0]         wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/indexed_framebuffer_fill_blit_scanout_top.sv */
// Indexed framebuffer engine: command sequencer, pixel and palette stores, scanout.
// Usage:
//   Requests enter on the in_ channel (valid/ready). Rectangle fill, blit start,
//   blit data and palette write produce no result; scan pixel produces one
//   palette-expanded pixel on the out_ channel (valid/ready).
//   User sets frame size and color model on the APB port only while idle; no check.
// Timing:
//   Blit start, blit data, palette write: accepted back to back.
//   Rectangle fill: pixels are written in turn while in_ready is held low.
//   Scan pixel: the shared multiply-add (frame size), then the pixel read, the
//   palette read and the output register; no new request until it completes.
//   Pixel write addresses use the one shared multiply-add unit; scan reads do not.
// Reset:
//   Synchronous, active low. Control state, scan position, blit window and
//   registers return to their defaults; pixel and palette memories are not
//   cleared and must be written before scanout.
// Stall:
//   A finished pixel waits in the output register; the next request is taken
//   meanwhile, and a later scan holds in its last step until the register frees.
`default_nettype none
module indexed_framebuffer_fill_blit_scanout_top #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ifb_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_command,
  input  wire logic [7:0]                  in_x,
  input  wire logic [7:0]                  in_y,
  input  wire logic [8:0]                  in_rect_width,
  input  wire logic [8:0]                  in_rect_height,
  input  wire logic [7:0]                  in_palette_index,
  input  wire logic [23:0]                 in_color_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [23:0]                 out_pixel_color,
  output logic      [1:0]                  out_byte_count,
  output logic                             out_last_of_frame
);

  localparam int DW  = ifb_pkg::DIM_W;
  localparam int PW  = ifb_pkg::PROD_W;
  localparam int AW  = $clog2(ifb_pkg::MAX_WIDTH * ifb_pkg::MAX_HEIGHT);
  localparam int TW  = $clog2(ifb_pkg::MAX_WIDTH * ifb_pkg::MAX_HEIGHT + 1);
  localparam int PAW = $clog2(PALETTE_DEPTH);

  // configuration
  logic [DW-1:0] fw_r;
  logic [DW-1:0] fh_r;
  logic          cm_r;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= DW'(256);
      fh_r <= DW'(256);
      cm_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        ifb_pkg::REG_FRAME_WIDTH:  fw_r <= pwdata[DW-1:0];
        ifb_pkg::REG_FRAME_HEIGHT: fh_r <= pwdata[DW-1:0];
        ifb_pkg::REG_COLOR_MODEL:  cm_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ifb_pkg::REG_FRAME_WIDTH:  prdata = {{(32-DW){1'b0}}, fw_r};
      ifb_pkg::REG_FRAME_HEIGHT: prdata = {{(32-DW){1'b0}}, fh_r};
      ifb_pkg::REG_COLOR_MODEL:  prdata = {31'b0, cm_r};
      default:                   prdata = 32'b0;
    endcase
  end

  // effective frame size
  logic [DW-1:0] eff_w;
  logic [DW-1:0] eff_h;

  always_comb begin
    if (fw_r == '0) begin
      eff_w = DW'(1);
    end else if (32'(fw_r) > ifb_pkg::MAX_WIDTH) begin
      eff_w = DW'(ifb_pkg::MAX_WIDTH);
    end else begin
      eff_w = fw_r;
    end
    if (fh_r == '0) begin
      eff_h = DW'(1);
    end else if (32'(fh_r) > ifb_pkg::MAX_HEIGHT) begin
      eff_h = DW'(ifb_pkg::MAX_HEIGHT);
    end else begin
      eff_h = fh_r;
    end
  end

  // sequencer state
  ifb_pkg::state_t state_r, state_nxt;
  logic [DW-1:0]   row_r, row_nxt;
  logic [DW-1:0]   col_r, col_nxt;
  logic [DW-1:0]   fx_r, fx_nxt;
  logic [DW:0]     endr_r, endr_nxt;
  logic [DW:0]     endc_r, endc_nxt;
  logic [7:0]      fidx_r, fidx_nxt;
  logic [DW:0]     brow_r, brow_nxt;
  logic [7:0]      bleft_r, bleft_nxt;
  logic [DW-1:0]   bcol_r, bcol_nxt;
  logic [DW-1:0]   bspan_r, bspan_nxt;
  logic [DW-1:0]   brows_r, brows_nxt;
  logic [AW-1:0]   scan_r, scan_nxt;
  logic [TW-1:0]   tot_r, tot_nxt;
  logic            inr_r, inr_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic [7:0]      wr_data_r, wr_data_nxt;
  logic            ov_r, ov_nxt;
  logic [23:0]     opc_r, opc_nxt;
  logic [1:0]      obc_r, obc_nxt;
  logic            olf_r, olf_nxt;

  // shared unit and memories
  logic            mac_en;
  logic [DW-1:0]   mac_a, mac_b, mac_c;
  logic [PW-1:0]   mac_res;
  logic            pal_we;
  logic            pix_re, pal_re;
  logic [AW-1:0]   pix_raddr;
  logic [7:0]      pix_rdata;
  logic [23:0]     pal_rdata;

  ifb_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .res (mac_res)
  );

  ifb_ram #(.DATA_W(8), .DEPTH(ifb_pkg::MAX_WIDTH * ifb_pkg::MAX_HEIGHT)) u_pix (
    .clk   (clk),
    .we    (wr_pend_r),
    .waddr (AW'(mac_res)),
    .wdata (wr_data_r),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  ifb_ram #(.DATA_W(24), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PAW'(in_palette_index)),
    .wdata (in_color_value),
    .re    (pal_re),
    .raddr (PAW'(pix_rdata)),
    .rdata (pal_rdata)
  );

  logic          acc;
  logic [DW:0]   fend_r_c, fend_c_c;
  logic [DW:0]   bcolp;
  logic [TW-1:0] scan_ext;
  logic [23:0]   entry;

  assign in_ready = (state_r == ifb_pkg::ST_IDLE);
  assign acc      = in_valid & in_ready;
  assign scan_ext = TW'(scan_r);
  assign bcolp    = (DW+1)'(bleft_r) + (DW+1)'(bcol_r);
  assign entry    = inr_r ? pal_rdata : 24'b0;

  always_comb begin
    fend_r_c = (DW+1)'(in_y) + (DW+1)'(in_rect_height);
    if (fend_r_c > (DW+1)'(eff_h)) begin
      fend_r_c = (DW+1)'(eff_h);
    end
    fend_c_c = (DW+1)'(in_x) + (DW+1)'(in_rect_width);
    if (fend_c_c > (DW+1)'(eff_w)) begin
      fend_c_c = (DW+1)'(eff_w);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    fx_nxt      = fx_r;
    endr_nxt    = endr_r;
    endc_nxt    = endc_r;
    fidx_nxt    = fidx_r;
    brow_nxt    = brow_r;
    bleft_nxt   = bleft_r;
    bcol_nxt    = bcol_r;
    bspan_nxt   = bspan_r;
    brows_nxt   = brows_r;
    scan_nxt    = scan_r;
    tot_nxt     = tot_r;
    inr_nxt     = inr_r;
    wr_pend_nxt = 1'b0;
    wr_data_nxt = wr_data_r;
    ov_nxt      = ov_r & ~out_ready;
    opc_nxt     = opc_r;
    obc_nxt     = obc_r;
    olf_nxt     = olf_r;
    mac_en      = 1'b0;
    mac_a       = row_r;
    mac_b       = eff_w;
    mac_c       = col_r;
    pal_we      = 1'b0;
    pix_re      = 1'b0;
    pal_re      = 1'b0;
    pix_raddr   = scan_r;

    unique case (state_r)
      ifb_pkg::ST_IDLE: begin
        if (acc) begin
          case (ifb_pkg::cmd_t'(in_command))
            ifb_pkg::CMD_FILL: begin
              row_nxt  = DW'(in_y);
              col_nxt  = DW'(in_x);
              fx_nxt   = DW'(in_x);
              endr_nxt = fend_r_c;
              endc_nxt = fend_c_c;
              fidx_nxt = in_palette_index;
              if (((DW+1)'(in_y) < fend_r_c) && ((DW+1)'(in_x) < fend_c_c)) begin
                state_nxt = ifb_pkg::ST_FILL;
              end
            end
            ifb_pkg::CMD_BLIT_START: begin
              bleft_nxt = in_x;
              brow_nxt  = (DW+1)'(in_y);
              bspan_nxt = in_rect_width;
              brows_nxt = (in_rect_width == '0) ? '0 : in_rect_height;
              bcol_nxt  = '0;
            end
            ifb_pkg::CMD_BLIT_DATA: begin
              if ((brows_r != '0) && (bspan_r != '0)) begin
                if ((bcolp < (DW+1)'(eff_w)) && (brow_r < (DW+1)'(eff_h))) begin
                  mac_en      = 1'b1;
                  mac_a       = brow_r[DW-1:0];
                  mac_c       = bcolp[DW-1:0];
                  wr_pend_nxt = 1'b1;
                  wr_data_nxt = in_palette_index;
                end
                if ((DW+1)'(bcol_r) + (DW+1)'(1) >= (DW+1)'(bspan_r)) begin
                  bcol_nxt  = '0;
                  brow_nxt  = brow_r + (DW+1)'(1);
                  brows_nxt = brows_r - DW'(1);
                end else begin
                  bcol_nxt = bcol_r + DW'(1);
                end
              end
            end
            ifb_pkg::CMD_PAL_WRITE: begin
              pal_we = (32'(in_palette_index) < PALETTE_DEPTH);
            end
            ifb_pkg::CMD_SCAN: begin
              mac_en    = 1'b1;
              mac_a     = eff_w;
              mac_b     = eff_h;
              mac_c     = '0;
              state_nxt = ifb_pkg::ST_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      ifb_pkg::ST_FILL: begin
        mac_en      = 1'b1;
        wr_pend_nxt = 1'b1;
        wr_data_nxt = fidx_r;
        if ((DW+1)'(col_r) + (DW+1)'(1) == endc_r) begin
          col_nxt = fx_r;
          row_nxt = row_r + DW'(1);
          if ((DW+1)'(row_r) + (DW+1)'(1) == endr_r) begin
            state_nxt = ifb_pkg::ST_IDLE;
          end
        end else begin
          col_nxt = col_r + DW'(1);
        end
      end
      ifb_pkg::ST_SCAN_RD: begin
        tot_nxt = TW'(mac_res);
        if (scan_ext >= TW'(mac_res)) begin
          pix_raddr = '0;
        end
        scan_nxt  = pix_raddr;
        pix_re    = 1'b1;
        state_nxt = ifb_pkg::ST_SCAN_PAL;
      end
      ifb_pkg::ST_SCAN_PAL: begin
        pal_re    = 1'b1;
        inr_nxt   = (32'(pix_rdata) < PALETTE_DEPTH);
        state_nxt = ifb_pkg::ST_SCAN_OUT;
      end
      ifb_pkg::ST_SCAN_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          if (cm_r) begin
            opc_nxt = entry;
            obc_nxt = ifb_pkg::BYTES_RGB666;
          end else begin
            opc_nxt = {8'b0, entry[15:0]};
            obc_nxt = ifb_pkg::BYTES_RGB565;
          end
          if (scan_ext == tot_r - TW'(1)) begin
            olf_nxt  = 1'b1;
            scan_nxt = '0;
          end else begin
            olf_nxt  = 1'b0;
            scan_nxt = scan_r + AW'(1);
          end
          state_nxt = ifb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ifb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ifb_pkg::ST_IDLE;
      brow_r    <= '0;
      bleft_r   <= '0;
      bcol_r    <= '0;
      bspan_r   <= '0;
      brows_r   <= '0;
      scan_r    <= '0;
      wr_pend_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      brow_r    <= brow_nxt;
      bleft_r   <= bleft_nxt;
      bcol_r    <= bcol_nxt;
      bspan_r   <= bspan_nxt;
      brows_r   <= brows_nxt;
      scan_r    <= scan_nxt;
      wr_pend_r <= wr_pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    fx_r      <= fx_nxt;
    endr_r    <= endr_nxt;
    endc_r    <= endc_nxt;
    fidx_r    <= fidx_nxt;
    tot_r     <= tot_nxt;
    inr_r     <= inr_nxt;
    wr_data_r <= wr_data_nxt;
    opc_r     <= opc_nxt;
    obc_r     <= obc_nxt;
    olf_r     <= olf_nxt;
  end

  assign out_valid         = ov_r;
  assign out_pixel_color   = opc_r;
  assign out_byte_count    = obc_r;
  assign out_last_of_frame = olf_r;

endmodule
`default_nettype wire
